// ===== sv/dft_pkg.sv =====
// ----------------------------------------------------------------------------
// dft_pkg
// Shared constants and types for the deadline feasibility tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package dft_pkg;

    localparam int MAX_TASKS_DEF     = 64;
    localparam int TIME_BITS_DEF     = 16;
    localparam int DEADLINE_BITS_DEF = 20;

    localparam int MODE_W  = 2;
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;
    localparam int MASK_W  = 64;

    localparam logic [CNT_W-1:0] TASK_COUNT_RST = 7'd64;

    localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PLAN    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_REJ = 1'b1;

    typedef struct packed {
        logic load;
        logic restart;
        logic plan;
    } t_cell_cmd;

    typedef struct packed {
        logic feasible;
        logic drop_f;
        logic drop_b;
        logic busy;
    } t_cell_stat;

endpackage

`default_nettype wire

// ===== sv/dft_cell.sv =====
// ----------------------------------------------------------------------------
// dft_cell
// One task slot of the chain: stored task, working deadline, slack, flags,
// and the forward / backward token stages handed to its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module dft_cell #(
    parameter int IDX           = 0,
    parameter int TIME_BITS     = 16,
    parameter int DEADLINE_BITS = 20,
    parameter int W             = 26
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  dft_pkg::t_cell_cmd               i_cmd,
    input  wire [dft_pkg::IDX_W-1:0]         i_idx,
    input  wire [dft_pkg::CNT_W-1:0]         i_n,
    input  wire [TIME_BITS-1:0]              i_time,
    input  wire [DEADLINE_BITS-1:0]          i_deadline,
    input  wire                              i_fwd_tok,
    input  wire [TIME_BITS-1:0]              i_fwd_tt,
    input  wire                              i_bwd_tok,
    input  wire signed [W-1:0]               i_bwd_mov,
    output logic                             o_fwd_tok,
    output logic [TIME_BITS-1:0]             o_fwd_tt,
    output logic                             o_bwd_tok,
    output logic signed [W-1:0]              o_bwd_mov,
    output dft_pkg::t_cell_stat              o_stat
);
    import dft_pkg::*;

    logic [TIME_BITS-1:0]     r_time,    n_time;
    logic [DEADLINE_BITS-1:0] r_dl,      n_dl;
    logic signed [W-1:0]      r_wd,      n_wd;
    logic signed [W-1:0]      r_slack,   n_slack;
    logic                     r_planned, n_planned;
    logic                     r_feas,    n_feas;
    logic                     r_fo_tok,  n_fo_tok;
    logic [TIME_BITS-1:0]     r_fo_tt,   n_fo_tt;
    logic                     r_bo_tok,  n_bo_tok;
    logic signed [W-1:0]      r_bo_mov,  n_bo_mov;

    logic                     w_hit;
    logic                     w_active;
    logic signed [W-1:0]      w_t_ext;
    logic signed [W-1:0]      w_d_ext;
    logic signed [W-1:0]      w_tt_ext;
    logic signed [W-1:0]      w_fwd_slack;
    logic signed [W-1:0]      w_bwd_slack;
    logic                     w_drop_f;
    logic                     w_drop_b;

    assign w_hit       = (i_idx == IDX_W'(IDX));
    assign w_active    = (CNT_W'(IDX) < i_n);
    assign w_t_ext     = $signed({{(W-TIME_BITS){1'b0}}, r_time});
    assign w_d_ext     = $signed({{(W-DEADLINE_BITS){1'b0}}, r_dl});
    assign w_tt_ext    = $signed({{(W-TIME_BITS){1'b0}}, i_fwd_tt});
    assign w_fwd_slack = r_slack - w_tt_ext;
    assign w_bwd_slack = r_slack + i_bwd_mov - r_wd;

    always_comb begin
        n_time    = r_time;
        n_dl      = r_dl;
        n_wd      = r_wd;
        n_slack   = r_slack;
        n_planned = r_planned;
        n_feas    = r_feas;
        n_fo_tok  = 1'b0;
        n_fo_tt   = r_fo_tt;
        n_bo_tok  = 1'b0;
        n_bo_mov  = r_bo_mov;
        w_drop_f  = 1'b0;
        w_drop_b  = 1'b0;

        if (i_cmd.load && w_hit) begin
            n_time = i_time;
            n_dl   = i_deadline;
        end

        if (i_cmd.restart) begin
            n_planned = 1'b0;
            n_feas    = w_active;
            if (w_active) begin
                n_wd    = w_d_ext;
                n_slack = w_d_ext - w_t_ext;
            end
        end

        // launch point of both sweeps
        if (i_cmd.plan && w_hit) begin
            n_planned = 1'b1;
            n_feas    = 1'b0;
            w_drop_f  = r_feas;
            n_fo_tok  = 1'b1;
            n_fo_tt   = r_time;
            n_bo_tok  = 1'b1;
            n_bo_mov  = r_wd - w_t_ext;
        end

        if (i_fwd_tok) begin
            n_fo_tok = 1'b1;
            n_fo_tt  = i_fwd_tt;
            if (r_feas) begin
                n_slack = w_fwd_slack;
                if (w_fwd_slack < 0) begin
                    n_feas   = 1'b0;
                    w_drop_f = 1'b1;
                end
            end
        end

        if (i_bwd_tok && (i_bwd_mov < r_wd)) begin
            n_wd     = i_bwd_mov;
            n_slack  = w_bwd_slack;
            n_bo_tok = 1'b1;
            n_bo_mov = r_planned ? (i_bwd_mov - w_t_ext) : i_bwd_mov;
            if (r_feas && (w_bwd_slack < 0)) begin
                n_feas   = 1'b0;
                w_drop_b = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_planned <= 1'b0;
            r_feas    <= 1'b0;
            r_fo_tok  <= 1'b0;
            r_bo_tok  <= 1'b0;
        end else begin
            r_planned <= n_planned;
            r_feas    <= n_feas;
            r_fo_tok  <= n_fo_tok;
            r_bo_tok  <= n_bo_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_time   <= n_time;
        r_dl     <= n_dl;
        r_wd     <= n_wd;
        r_slack  <= n_slack;
        r_fo_tt  <= n_fo_tt;
        r_bo_mov <= n_bo_mov;
    end

    assign o_fwd_tok       = r_fo_tok;
    assign o_fwd_tt        = r_fo_tt;
    assign o_bwd_tok       = r_bo_tok;
    assign o_bwd_mov       = r_bo_mov;
    assign o_stat.feasible = r_feas;
    assign o_stat.drop_f   = w_drop_f;
    assign o_stat.drop_b   = w_drop_b;
    assign o_stat.busy     = r_fo_tok | r_bo_tok;

endmodule

`default_nettype wire

// ===== sv/deadline_feasibility_tracker_top.sv =====
// ----------------------------------------------------------------------------
// deadline_feasibility_tracker_top
// Feasibility tracker for a constructive deadline scheduler.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one command word: load a
//   task, plan a task or restart the working state. Output channel
//   (o_out_valid / i_out_ready) returns one word per command: status, mask of
//   still feasible tasks and their count, as they stand after the command.
//   task_count is written through i_cfg_we / i_cfg_data while idle.
// Operation:
//   Load, restart and rejected plans: result registered from the finish state.
//   Plan of task t: a forward token walks cells t+1..MAX_TASKS-1 and a
//   backward token walks from t-1 towards 0 in parallel, one cell per cycle,
//   until it no longer lowers a working deadline; the result is registered
//   once no token is left in the chain. One word is in work at a time; the
//   next word is taken once the result is registered.
// Reset: all tasks infeasible, not planned, count zero, task_count 64.
//   Stored tasks are undefined until loaded.
// Stall: a finished word waits in the output register; a completed result
//   is held internally until that register frees, and the input waits.
// ----------------------------------------------------------------------------
`default_nettype none

module deadline_feasibility_tracker_top #(
    parameter int MAX_TASKS     = dft_pkg::MAX_TASKS_DEF,
    parameter int TIME_BITS     = dft_pkg::TIME_BITS_DEF,
    parameter int DEADLINE_BITS = dft_pkg::DEADLINE_BITS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [dft_pkg::CNT_W-1:0]         i_cfg_data,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire [dft_pkg::MODE_W-1:0]        i_mode,
    input  wire [dft_pkg::IDX_W-1:0]         i_task_index,
    input  wire [TIME_BITS-1:0]              i_task_time,
    input  wire [DEADLINE_BITS-1:0]          i_task_deadline,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic                             o_status,
    output logic [dft_pkg::MASK_W-1:0]       o_feasible_mask,
    output logic [dft_pkg::CNT_W-1:0]        o_feasible_count
);
    import dft_pkg::*;

    localparam int IW   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int WMAX = (DEADLINE_BITS > TIME_BITS + 7) ? DEADLINE_BITS : TIME_BITS + 7;
    localparam int W    = WMAX + 3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } t_state;

    t_state                r_state;
    logic [CNT_W-1:0]      r_task_count;
    logic [CNT_W-1:0]      r_count;
    logic                  r_stat;
    logic                  r_out_valid;
    logic                  r_out_status;
    logic [MASK_W-1:0]     r_out_mask;
    logic [CNT_W-1:0]      r_out_count;

    logic                  w_accept;
    logic [CNT_W-1:0]      w_n;
    logic [CNT_W-1:0]      w_idx7;
    logic                  w_load_ok;
    logic                  w_plan_ok;
    logic                  w_status;
    logic [CNT_W-1:0]      w_dec;
    logic [MASK_W-1:0]     w_mask;
    logic                  w_busy;
    logic                  w_out_load;
    t_cell_cmd             w_cmd;

    logic [MAX_TASKS-1:0]  w_feas;
    logic [MAX_TASKS-1:0]  w_drop_f;
    logic [MAX_TASKS-1:0]  w_drop_b;
    logic [MAX_TASKS-1:0]  w_busy_v;
    logic                  w_fo_tok [MAX_TASKS];
    logic [TIME_BITS-1:0]  w_fo_tt  [MAX_TASKS];
    logic                  w_bo_tok [MAX_TASKS];
    logic signed [W-1:0]   w_bo_mov [MAX_TASKS];
    t_cell_stat            w_stat   [MAX_TASKS];

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_n        = (r_task_count > CNT_W'(MAX_TASKS)) ? CNT_W'(MAX_TASKS) : r_task_count;
    assign w_idx7     = {1'b0, i_task_index};
    assign w_load_ok  = (w_idx7 < CNT_W'(MAX_TASKS));
    assign w_plan_ok  = (w_idx7 < w_n) && w_feas[i_task_index[IW-1:0]];

    always_comb begin
        case (i_mode)
            MODE_LOAD:    w_status = w_load_ok ? STATUS_OK : STATUS_REJ;
            MODE_PLAN:    w_status = w_plan_ok ? STATUS_OK : STATUS_REJ;
            MODE_RESTART: w_status = STATUS_OK;
            default:      w_status = STATUS_REJ;
        endcase
    end

    assign w_cmd.load    = w_accept && (i_mode == MODE_LOAD) && w_load_ok;
    assign w_cmd.plan    = w_accept && (i_mode == MODE_PLAN) && w_plan_ok;
    assign w_cmd.restart = w_accept && (i_mode == MODE_RESTART);

    // at most one drop per sweep per cycle
    assign w_dec  = CNT_W'(|w_drop_f) + CNT_W'(|w_drop_b);
    assign w_busy = |w_busy_v;

    assign w_out_load = (r_state == ST_FIN) && (!r_out_valid || i_out_ready);

    always_comb begin
        w_mask = '0;
        w_mask[MAX_TASKS-1:0] = w_feas;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TASKS; gi++) begin : g_cell
            logic                 w_fi_tok;
            logic [TIME_BITS-1:0] w_fi_tt;
            logic                 w_bi_tok;
            logic signed [W-1:0]  w_bi_mov;

            if (gi == 0) begin : g_lo
                assign w_fi_tok = 1'b0;
                assign w_fi_tt  = '0;
            end else begin : g_lo
                assign w_fi_tok = w_fo_tok[gi-1];
                assign w_fi_tt  = w_fo_tt[gi-1];
            end

            if (gi == MAX_TASKS - 1) begin : g_hi
                assign w_bi_tok = 1'b0;
                assign w_bi_mov = '0;
            end else begin : g_hi
                assign w_bi_tok = w_bo_tok[gi+1];
                assign w_bi_mov = w_bo_mov[gi+1];
            end

            dft_cell #(
                .IDX           (gi),
                .TIME_BITS     (TIME_BITS),
                .DEADLINE_BITS (DEADLINE_BITS),
                .W             (W)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_cmd      (w_cmd),
                .i_idx      (i_task_index),
                .i_n        (w_n),
                .i_time     (i_task_time),
                .i_deadline (i_task_deadline),
                .i_fwd_tok  (w_fi_tok),
                .i_fwd_tt   (w_fi_tt),
                .i_bwd_tok  (w_bi_tok),
                .i_bwd_mov  (w_bi_mov),
                .o_fwd_tok  (w_fo_tok[gi]),
                .o_fwd_tt   (w_fo_tt[gi]),
                .o_bwd_tok  (w_bo_tok[gi]),
                .o_bwd_mov  (w_bo_mov[gi]),
                .o_stat     (w_stat[gi])
            );

            assign w_feas[gi]   = w_stat[gi].feasible;
            assign w_drop_f[gi] = w_stat[gi].drop_f;
            assign w_drop_b[gi] = w_stat[gi].drop_b;
            assign w_busy_v[gi] = w_stat[gi].busy;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_count <= TASK_COUNT_RST;
        end else if (i_cfg_we) begin
            r_task_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_cmd.restart) begin
            r_count <= w_n;
        end else begin
            r_count <= r_count - w_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_stat  <= w_status;
                        r_state <= w_cmd.plan ? ST_RUN : ST_FIN;
                    end
                end
                ST_RUN: begin
                    if (!w_busy) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (w_out_load) begin
                        r_out_status <= r_stat;
                        r_out_mask   <= w_mask;
                        r_out_count  <= r_count;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_feasible_mask  = r_out_mask;
    assign o_feasible_count = r_out_count;

endmodule

`default_nettype wire

// ===== sim/tb_deadline_feasibility_tracker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_deadline_feasibility_tracker_top
// Self-checking bench: a directed table, then random scheduling sessions
// (load, restart, plan) under several task counts, with bursty input and a
// stalling output, each word scored against its table entry or an in-bench tracker model.
// ----------------------------------------------------------------------------
module tb_deadline_feasibility_tracker_top;
    import dft_pkg::*;

    localparam int NTASK         = MAX_TASKS_DEF;
    localparam int TIME_W        = TIME_BITS_DEF;
    localparam int DL_W          = DEADLINE_BITS_DEF;
    localparam int WORD_TARGET   = 1450;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 80;
    localparam int DIR_ROWS      = 23;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic              status;
        logic [MASK_W-1:0] mask;
        logic [CNT_W-1:0]  count;
    } feas_report_t;

    typedef struct packed {
        logic              do_cfg;
        logic [CNT_W-1:0]  cfg_val;
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  idx;
        logic [TIME_W-1:0] t;
        logic [DL_W-1:0]   dl;
        logic              typed;
        logic              st;
        logic [MASK_W-1:0] mask;
        logic [CNT_W-1:0]  cnt;
    } dir_row_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CNT_W-1:0]  i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [MODE_W-1:0] i_mode = '0;
    logic [IDX_W-1:0]  i_task_index = '0;
    logic [TIME_W-1:0] i_task_time = '0;
    logic [DL_W-1:0]   i_task_deadline = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic              o_status;
    logic [MASK_W-1:0] o_feasible_mask;
    logic [CNT_W-1:0]  o_feasible_count;

    always #5 i_clk = ~i_clk;

    deadline_feasibility_tracker_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_mode           (i_mode),
        .i_task_index     (i_task_index),
        .i_task_time      (i_task_time),
        .i_task_deadline  (i_task_deadline),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_feasible_mask  (o_feasible_mask),
        .o_feasible_count (o_feasible_count)
    );

    // tracker shadow state
    logic [CNT_W-1:0]  tc_shadow;
    logic [TIME_W-1:0] st_time [NTASK];
    logic [DL_W-1:0]   st_dl [NTASK];
    longint            wdl [NTASK];
    longint            slk [NTASK];
    bit                planned [NTASK];
    bit                feas [NTASK];
    int                remain;

    feas_report_t feas_reports_q[$];
    feas_report_t want_rpt;
    int           burst_left = 0;
    int           words_sent = 0;
    int           fail_count = 0;
    int           shown = 0;
    int           idle_cycles = 0;
    int           rx_mode = 0;
    int           rx_left = 0;
    int           rx_period = 2;
    int           rx_phase = 0;

    function automatic int live_tasks();
        return (tc_shadow > NTASK) ? NTASK : int'(tc_shadow);
    endfunction

    function automatic void retire_task(int i);
        if (feas[i]) begin
            feas[i] = 1'b0;
            if (remain > 0)
                remain--;
        end
    endfunction

    function automatic feas_report_t advance_tracker(logic [MODE_W-1:0] m,
                                                     logic [IDX_W-1:0] idx,
                                                     logic [TIME_W-1:0] t,
                                                     logic [DL_W-1:0] d);
        feas_report_t r;
        int           n;
        int           i;
        int           k;
        int           ti;
        longint       tt;
        longint       moving;
        bit           rippling;
        n = live_tasks();
        ti = int'(idx);
        r.status = STATUS_OK;
        case (m)
            MODE_LOAD: begin
                st_time[ti] = t;
                st_dl[ti] = d;
            end
            MODE_PLAN: begin
                if (ti < n && feas[ti]) begin
                    tt = longint'(st_time[ti]);
                    planned[ti] = 1'b1;
                    for (i = ti + 1; i < NTASK; i++) begin
                        if (feas[i]) begin
                            slk[i] -= tt;
                            if (slk[i] < 0)
                                retire_task(i);
                        end
                    end
                    // backward ripple of the shrunken deadline
                    moving = wdl[ti] - tt;
                    i = ti;
                    rippling = 1'b1;
                    while (rippling && i > 0) begin
                        k = i - 1;
                        if (moving < wdl[k]) begin
                            slk[k] += moving - wdl[k];
                            wdl[k] = moving;
                            if (planned[k])
                                moving = wdl[k] - longint'(st_time[k]);
                            if (feas[k] && slk[k] < 0)
                                retire_task(k);
                            i--;
                        end else begin
                            rippling = 1'b0;
                        end
                    end
                    retire_task(ti);
                end else begin
                    r.status = STATUS_REJ;
                end
            end
            MODE_RESTART: begin
                remain = 0;
                for (i = 0; i < NTASK; i++) begin
                    planned[i] = 1'b0;
                    if (i < n) begin
                        wdl[i] = longint'(st_dl[i]);
                        slk[i] = longint'(st_dl[i]) - longint'(st_time[i]);
                        feas[i] = 1'b1;
                        remain++;
                    end else begin
                        feas[i] = 1'b0;
                    end
                end
            end
            default: r.status = STATUS_REJ;
        endcase
        for (i = 0; i < NTASK; i++)
            r.mask[i] = feas[i];
        r.count = CNT_W'(remain);
        return r;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input logic [MODE_W-1:0] m, input logic [IDX_W-1:0] idx,
                             input logic [TIME_W-1:0] t, input logic [DL_W-1:0] d,
                             input bit typed, input feas_report_t typed_rpt);
        int           gap;
        feas_report_t pred;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 20);
            if (gap > 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid = 1'b1;
        i_mode = m;
        i_task_index = idx;
        i_task_time = t;
        i_task_deadline = d;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        pred = advance_tracker(m, idx, t, d);
        feas_reports_q.push_back(typed ? typed_rpt : pred);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (feas_reports_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_task_count(input logic [CNT_W-1:0] v);
        wait_drained();
        i_cfg_we = 1'b1;
        i_cfg_data = v;
        tc_shadow = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // output side stall pattern
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(20, 200);
            rx_period = $urandom_range(2, 20);
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
            0: i_out_ready = 1'b1;
            1: i_out_ready = $urandom_range(0, 1);
            default: i_out_ready = (rx_phase % rx_period == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (feas_reports_q.size() == 0) begin
                fail_count++;
                if (shown < 10) begin
                    shown++;
                    $display("unexpected word: status %0d mask %h count %0d",
                             o_status, o_feasible_mask, o_feasible_count);
                end
            end else begin
                want_rpt = feas_reports_q.pop_front();
                if (o_status !== want_rpt.status || o_feasible_mask !== want_rpt.mask ||
                    o_feasible_count !== want_rpt.count) begin
                    fail_count++;
                    if (shown < 10) begin
                        shown++;
                        $display("mismatch: status exp %0d act %0d, mask exp %h act %h, count exp %0d act %0d",
                                 want_rpt.status, o_status, want_rpt.mask, o_feasible_mask,
                                 want_rpt.count, o_feasible_count);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("deadline_feasibility_tracker_top test failed");
            $finish;
        end
    end

    initial begin
        dir_row_t dir_tbl [DIR_ROWS];
        int       r;
        int       i;
        int       cfg_v;
        int       n_eff;
        int       choice;
        int       tmax;
        int       cum;
        int       ti;
        int       di;
        int       pick;
        int       steps;
        bit       shaped;

        tc_shadow = TASK_COUNT_RST;
        remain = 0;
        for (i = 0; i < NTASK; i++) begin
            st_time[i] = '0;
            st_dl[i] = '0;
            wdl[i] = 0;
            slk[i] = 0;
            planned[i] = 1'b0;
            feas[i] = 1'b0;
        end

        //                cfg   value  mode          idx    time      deadline    typed status      mask    count
        dir_tbl[0]  = '{1'b0, 7'd0,   MODE_PLAN,    6'd0,  16'h0,    20'h0,     1'b1, STATUS_REJ, 64'h0, 7'd0};
        dir_tbl[1]  = '{1'b0, 7'd0,   MODE_UNUSED,  6'd63, 16'hFFFF, 20'hFFFFF, 1'b1, STATUS_REJ, 64'h0, 7'd0};
        dir_tbl[2]  = '{1'b0, 7'd0,   MODE_LOAD,    6'd63, 16'hFFFF, 20'hFFFFF, 1'b1, STATUS_OK,  64'h0, 7'd0};
        dir_tbl[3]  = '{1'b0, 7'd0,   MODE_LOAD,    6'd0,  16'h0,    20'h0,     1'b1, STATUS_OK,  64'h0, 7'd0};
        dir_tbl[4]  = '{1'b1, 7'd0,   MODE_RESTART, 6'd0,  16'h0,    20'h0,     1'b1, STATUS_OK,  64'h0, 7'd0};
        dir_tbl[5]  = '{1'b0, 7'd0,   MODE_PLAN,    6'd0,  16'h0,    20'h0,     1'b1, STATUS_REJ, 64'h0, 7'd0};
        dir_tbl[6]  = '{1'b1, 7'd4,   MODE_LOAD,    6'd1,  16'd10,   20'd30,    1'b1, STATUS_OK,  64'h0, 7'd0};
        dir_tbl[7]  = '{1'b0, 7'd0,   MODE_LOAD,    6'd2,  16'd20,   20'd50,    1'b1, STATUS_OK,  64'h0, 7'd0};
        dir_tbl[8]  = '{1'b0, 7'd0,   MODE_LOAD,    6'd3,  16'd15,   20'd60,    1'b1, STATUS_OK,  64'h0, 7'd0};
        dir_tbl[9]  = '{1'b0, 7'd0,   MODE_RESTART, 6'd0,  16'h0,    20'h0,     1'b1, STATUS_OK,  64'hF, 7'd4};
        dir_tbl[10] = '{1'b0, 7'd0,   MODE_PLAN,    6'd4,  16'h0,    20'h0,     1'b1, STATUS_REJ, 64'hF, 7'd4};
        dir_tbl[11] = '{1'b0, 7'd0,   MODE_PLAN,    6'd2,  16'h0,    20'h0,     1'b0, 1'b0,       64'h0, 7'd0};
        dir_tbl[12] = '{1'b0, 7'd0,   MODE_PLAN,    6'd2,  16'h0,    20'h0,     1'b0, 1'b0,       64'h0, 7'd0};
        dir_tbl[13] = '{1'b0, 7'd0,   MODE_PLAN,    6'd1,  16'h0,    20'h0,     1'b0, 1'b0,       64'h0, 7'd0};
        dir_tbl[14] = '{1'b0, 7'd0,   MODE_PLAN,    6'd0,  16'h0,    20'h0,     1'b0, 1'b0,       64'h0, 7'd0};
        dir_tbl[15] = '{1'b0, 7'd0,   MODE_UNUSED,  6'd1,  16'h5,    20'h5,     1'b0, 1'b0,       64'h0, 7'd0};
        dir_tbl[16] = '{1'b0, 7'd0,   MODE_LOAD,    6'd2,  16'h0,    20'h0,     1'b0, 1'b0,       64'h0, 7'd0};
        dir_tbl[17] = '{1'b0, 7'd0,   MODE_LOAD,    6'd10, 16'd5,    20'd5,     1'b0, 1'b0,       64'h0, 7'd0};
        dir_tbl[18] = '{1'b0, 7'd0,   MODE_RESTART, 6'd0,  16'h0,    20'h0,     1'b1, STATUS_OK,  64'hF, 7'd4};
        dir_tbl[19] = '{1'b0, 7'd0,   MODE_PLAN,    6'd3,  16'h0,    20'h0,     1'b0, 1'b0,       64'h0, 7'd0};
        dir_tbl[20] = '{1'b1, 7'd127, MODE_PLAN,    6'd63, 16'h0,    20'h0,     1'b0, 1'b0,       64'h0, 7'd0};
        dir_tbl[21] = '{1'b0, 7'd0,   MODE_LOAD,    6'd63, 16'd1,    20'd2,     1'b0, 1'b0,       64'h0, 7'd0};
        dir_tbl[22] = '{1'b1, 7'd64,  MODE_PLAN,    6'd0,  16'h0,    20'h0,     1'b0, 1'b0,       64'h0, 7'd0};

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (r = 0; r < DIR_ROWS; r++) begin
            if (dir_tbl[r].do_cfg)
                write_task_count(dir_tbl[r].cfg_val);
            send_word(dir_tbl[r].mode, dir_tbl[r].idx, dir_tbl[r].t, dir_tbl[r].dl,
                      dir_tbl[r].typed,
                      '{dir_tbl[r].st, dir_tbl[r].mask, dir_tbl[r].cnt});
        end

        // random sessions: reconfigure, load every live entry, restart, plan
        while (words_sent < WORD_TARGET) begin
            choice = $urandom_range(0, 19);
            if (choice == 0)
                cfg_v = 0;
            else if (choice == 1)
                cfg_v = 64;
            else if (choice == 2)
                cfg_v = $urandom_range(65, 127);
            else if (choice == 3)
                cfg_v = 1;
            else if (choice <= 5)
                cfg_v = $urandom_range(9, 63);
            else
                cfg_v = $urandom_range(2, 8);
            write_task_count(cfg_v[CNT_W-1:0]);
            n_eff = (cfg_v > NTASK) ? NTASK : cfg_v;

            shaped = ($urandom_range(0, 3) != 0);
            tmax = $urandom_range(1, 4000);
            cum = 0;
            for (i = 0; i < n_eff; i++) begin
                if (shaped) begin
                    ti = $urandom_range(0, tmax);
                    cum += ti;
                    di = cum + $urandom_range(0, 2 * tmax);
                    if (di > 20'hFFFFF)
                        di = 20'hFFFFF;
                end else begin
                    ti = $urandom_range(0, 16'hFFFF);
                    di = $urandom_range(0, 20'hFFFFF);
                end
                send_word(MODE_LOAD, i[IDX_W-1:0], ti[TIME_W-1:0], di[DL_W-1:0], 1'b0, '0);
            end
            if ($urandom_range(0, 2) == 0)
                send_word(MODE_LOAD, IDX_W'($urandom_range(0, 63)),
                          TIME_W'($urandom_range(0, 16'hFFFF)),
                          DL_W'($urandom_range(0, 20'hFFFFF)), 1'b0, '0);
            send_word(MODE_RESTART, IDX_W'($urandom_range(0, 63)),
                      TIME_W'($urandom_range(0, 16'hFFFF)),
                      DL_W'($urandom_range(0, 20'hFFFFF)), 1'b0, '0);

            for (steps = 0; steps < 2 * n_eff + 3; steps++) begin
                choice = $urandom_range(0, 24);
                if (remain > 0 && choice < 19) begin
                    pick = $urandom_range(0, remain - 1);
                    i = 0;
                    while (!feas[i] || pick > 0) begin
                        if (feas[i])
                            pick--;
                        i++;
                    end
                    send_word(MODE_PLAN, i[IDX_W-1:0], TIME_W'($urandom_range(0, 16'hFFFF)),
                              DL_W'($urandom_range(0, 20'hFFFFF)), 1'b0, '0);
                end else if (choice < 21) begin
                    send_word(MODE_PLAN, IDX_W'($urandom_range(0, 63)),
                              TIME_W'($urandom_range(0, 16'hFFFF)),
                              DL_W'($urandom_range(0, 20'hFFFFF)), 1'b0, '0);
                end else begin
                    if (choice == 21)
                        i_mode = MODE_UNUSED;
                    else if (choice == 22)
                        i_mode = MODE_RESTART;
                    else
                        i_mode = MODE_LOAD;
                    send_word(i_mode, IDX_W'($urandom_range(0, 63)),
                              TIME_W'($urandom_range(0, 16'hFFFF)),
                              DL_W'($urandom_range(0, 20'hFFFFF)), 1'b0, '0);
                end
                if ($urandom_range(0, 49) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && feas_reports_q.size() == 0)
            $display("deadline_feasibility_tracker_top test passed");
        else
            $display("deadline_feasibility_tracker_top test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/dft_pkg.sv
sv/dft_cell.sv
sv/deadline_feasibility_tracker_top.sv
sim/tb_deadline_feasibility_tracker_top.sv
